FILE: sv/eeg_variation_calm_detector_assert.svh
// Assertion macros for the calm detector checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef EEG_VARIATION_CALM_DETECTOR_ASSERT_SVH
`define EEG_VARIATION_CALM_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define EVCD_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication
`define EVCD_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: sv/evcd_pkg.sv
// Shared types and constants for the EEG variation calm detector.
// No dependencies.
package evcd_pkg;

	typedef enum logic [1:0] {
		REQ_PACKET     = 2'd0,
		REQ_SAMPLE     = 2'd1,
		REQ_AVG_TICK   = 2'd2,
		REQ_FOCUS_TICK = 2'd3
	} req_type_t;

	localparam int unsigned LEVEL_W     = 25;
	localparam int unsigned CFG_W       = 25;
	localparam logic [CFG_W-1:0] CALM_RESET = 25'd1536;
	localparam int unsigned OUT_TDATA_W = ((LEVEL_W + 1 + 7) / 8) * 8;

	typedef struct packed {
		logic avg_tick;
		logic focus_tick;
	} stage_ctl_t;

endpackage

FILE: sv/evcd_cell.sv
// One window cell: holds a value and hands it to its neighbor on shift.
// No dependencies.
module evcd_cell #(
	parameter int unsigned W = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;
endmodule

FILE: sv/evcd_window.sv
// Sliding window as a row of evcd_cell with running sum and saturating fill count.
// Depends on evcd_cell.
module evcd_window #(
	parameter int unsigned DEPTH = 20,
	parameter int unsigned W     = 25,
	parameter int unsigned SUMW  = W + $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [W-1:0]    din,
	output logic [SUMW-1:0] sum,
	output logic            full
);
	localparam int unsigned CNTW = $clog2(DEPTH + 2);
	localparam logic [CNTW-1:0] CNT_SAT = CNTW'(DEPTH + 1);

	logic [W-1:0]    tap [DEPTH+1];
	logic [SUMW-1:0] sum_q;
	logic [CNTW-1:0] cnt_q;

	assign tap[0] = din;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		evcd_cell #(.W(W)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (push),
			.d     (tap[i]),
			.q     (tap[i+1])
		);
	end

	// oldest cell resets to zero, so subtracting it is always exact
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (push) begin
			sum_q <= sum_q + SUMW'(din) - SUMW'(tap[DEPTH]);
			if (cnt_q != CNT_SAT) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign sum  = sum_q;
	assign full = (cnt_q == CNT_SAT);
endmodule

FILE: sv/evcd_cdiv.sv
// Floor division by a constant: registered reciprocal product, exact for all XW-bit inputs.
// No dependencies.
module evcd_cdiv #(
	parameter int unsigned XW  = 30,
	parameter int unsigned DIV = 20,
	parameter int unsigned QW  = 25
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	output logic [QW-1:0] q
);
	localparam int unsigned SH = XW + $clog2(DIV);
	localparam int unsigned MW = XW + 1;
	localparam int unsigned PW = XW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((65'd1 << SH) + 65'(DIV) - 65'd1) / 65'(DIV));

	logic [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(x) * PW'(RECIP);
		end
	end

	assign q = prod_q[SH +: QW];
endmodule

FILE: sv/eeg_variation_calm_detector.sv
// EEG variation calm detector. Takes one transaction per clock; s_tready drops only while
// a focus result sits in the last stage and the output register is full and not taken.
// A focus result is registered in ctl_s1, then in res_s2, and is then loaded into the output
// register that drives m_tvalid; a stall holds it in res_s2. The two registered reciprocal
// multipliers (window means) set the stage count. Depends on evcd_pkg, evcd_window,
// evcd_cdiv.
module eeg_variation_calm_detector #(
	parameter int unsigned VARIATION_WINDOW = 20,
	parameter int unsigned AVERAGE_WINDOW   = 4,
	parameter int unsigned SAMPLE_BITS      = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	// req_type
	input  evcd_pkg::req_type_t                     s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// is_calm, focus_level
	output logic [evcd_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  logic                                    cfg_we,
	input  logic [evcd_pkg::CFG_W-1:0]              cfg_wdata
);
	import evcd_pkg::*;

	localparam int unsigned VBITS = SAMPLE_BITS + 1;
	localparam int unsigned VSUMW = VBITS + $clog2(VARIATION_WINDOW);
	localparam int unsigned ASUMW = VBITS + $clog2(AVERAGE_WINDOW);

	logic [CFG_W-1:0]              thr_q;
	logic signed [SAMPLE_BITS-1:0] last_q;
	logic                          have_last_q;
	stage_ctl_t                    ctl_s1;
	logic                          res_s2;
	logic                          out_valid_q;
	logic [LEVEL_W-1:0]            level_q;
	logic                          calm_q;

	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [VBITS-1:0]              var_abs;
	logic [VBITS-1:0]              var_din;
	logic                          var_push;
	logic [VSUMW-1:0]              var_sum;
	logic                          var_full;
	logic [VBITS-1:0]              avg_val;
	logic [ASUMW-1:0]              avg_sum;
	logic                          avg_full;
	logic [VBITS-1:0]              focus_q;
	logic [LEVEL_W-1:0]            level;
	logic                          stall;
	logic                          adv;
	logic                          acc;

	assign stall    = res_s2 && out_valid_q && !m_tready;
	assign adv      = !stall;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign sample_in = s_tdata[SAMPLE_BITS-1:0];
	assign diff      = {sample_in[SAMPLE_BITS-1], sample_in} - {last_q[SAMPLE_BITS-1], last_q};
	assign var_abs   = diff[SAMPLE_BITS] ? VBITS'(-diff) : VBITS'(diff);
	assign var_din   = (s_tuser == REQ_SAMPLE && have_last_q) ? var_abs : '0;
	assign var_push  = acc && (s_tuser == REQ_PACKET || s_tuser == REQ_SAMPLE);

	evcd_window #(.DEPTH(VARIATION_WINDOW), .W(VBITS), .SUMW(VSUMW)) u_var_win (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (var_push),
		.din   (var_din),
		.sum   (var_sum),
		.full  (var_full)
	);

	evcd_cdiv #(.XW(VSUMW), .DIV(VARIATION_WINDOW), .QW(VBITS)) u_var_div (
		.clk(clk),
		.en (adv),
		.x  (var_sum),
		.q  (avg_val)
	);

	evcd_window #(.DEPTH(AVERAGE_WINDOW), .W(VBITS), .SUMW(ASUMW)) u_avg_win (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (adv && ctl_s1.avg_tick),
		.din   (avg_val),
		.sum   (avg_sum),
		.full  (avg_full)
	);

	evcd_cdiv #(.XW(ASUMW), .DIV(AVERAGE_WINDOW), .QW(VBITS)) u_avg_div (
		.clk(clk),
		.en (adv),
		.x  (avg_sum),
		.q  (focus_q)
	);

	assign level = LEVEL_W'(focus_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= CALM_RESET;
			last_q      <= '0;
			have_last_q <= 1'b0;
			ctl_s1      <= '0;
			res_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (acc && s_tuser == REQ_SAMPLE) begin
				last_q      <= sample_in;
				have_last_q <= 1'b1;
			end
			if (adv) begin
				ctl_s1.avg_tick   <= acc && s_tuser == REQ_AVG_TICK && var_full;
				ctl_s1.focus_tick <= acc && s_tuser == REQ_FOCUS_TICK;
				res_s2            <= ctl_s1.focus_tick && avg_full;
			end
			if (adv && res_s2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s2) begin
			level_q <= level;
			calm_q  <= (level < thr_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({level_q, calm_q});
endmodule

FILE: sv/evcd_checker.sv
// Port-level checks for eeg_variation_calm_detector, bound to the top level.
// Depends on evcd_pkg and eeg_variation_calm_detector_assert.svh.
`include "eeg_variation_calm_detector_assert.svh"

module evcd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [evcd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import evcd_pkg::*;

	`EVCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	`EVCD_ASSERT_IMPL(a_ready_only_on_block, !s_tready, m_tvalid && !m_tready, "input stalled without a blocked result")

	`EVCD_ASSERT_IMPL(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 3), "result without a transaction three cycles earlier")

	`EVCD_ASSERT_IMPL(a_calm_below_max, m_tvalid && m_tdata[0], m_tdata[LEVEL_W:1] != '1, "calm flagged at largest focus level")
endmodule

bind eeg_variation_calm_detector evcd_checker u_evcd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: tb/tb_eeg_variation_calm_detector.sv
// Testbench for eeg_variation_calm_detector: directed and random EEG streams checked
// transaction by transaction against an in-bench model of the variation and focus windows.
// Depends on evcd_pkg and the detector RTL.
module tb_eeg_variation_calm_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import evcd_pkg::*;

	localparam int VAR_WIN = 20;
	localparam int AVG_WIN = 4;
	localparam logic [CFG_W-1:0] THRESH_MAX = '1;

	typedef struct {
		logic             calm;
		logic [LEVEL_W-1:0] level;
	} focus_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [23:0]            s_tdata;
	req_type_t              s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_W-1:0]       cfg_wdata;

	// model state
	logic signed [23:0]     prev_smp;
	bit                     have_prev;
	logic [24:0]            var_ring [VAR_WIN];
	int                     var_ptr;
	int                     var_cnt;
	logic [29:0]            var_sum;
	logic [24:0]            avg_ring [AVG_WIN];
	int                     avg_ptr;
	int                     avg_cnt;
	logic [26:0]            avg_sum;
	logic [CFG_W-1:0]       calm_thresh;

	focus_result_t          focus_expected [$];
	int                     errors;
	int                     src_max_gap;
	int                     snk_max_gap;
	logic signed [23:0]     walk_smp;

	eeg_variation_calm_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic push_variation(input logic [24:0] v);
		if (var_cnt >= VAR_WIN) var_sum -= var_ring[var_ptr];
		var_ring[var_ptr] = v;
		var_sum += v;
		var_ptr = (var_ptr + 1) % VAR_WIN;
		if (var_cnt < VAR_WIN + 1) var_cnt++;
	endtask

	task automatic push_average(input logic [24:0] a);
		if (avg_cnt >= AVG_WIN) avg_sum -= avg_ring[avg_ptr];
		avg_ring[avg_ptr] = a;
		avg_sum += a;
		avg_ptr = (avg_ptr + 1) % AVG_WIN;
		if (avg_cnt < AVG_WIN + 1) avg_cnt++;
	endtask

	function automatic logic [LEVEL_W-1:0] current_level();
		logic [26:0] q;
		q = avg_sum / AVG_WIN;
		return q[LEVEL_W-1:0];
	endfunction

	task automatic advance_calm_state(input req_type_t req, input logic [23:0] raw);
		logic signed [24:0] diff;
		logic [24:0]        v;
		logic [29:0]        mean;
		focus_result_t      r;
		unique case (req)
			REQ_PACKET: begin
				push_variation('0);
			end
			REQ_SAMPLE: begin
				v = '0;
				if (have_prev) begin
					diff = $signed({raw[23], raw}) - $signed({prev_smp[23], prev_smp});
					v = (diff < 0) ? 25'(-diff) : 25'(diff);
				end
				prev_smp = raw;
				have_prev = 1'b1;
				push_variation(v);
			end
			REQ_AVG_TICK: begin
				if (var_cnt > VAR_WIN) begin
					mean = var_sum / VAR_WIN;
					push_average(mean[24:0]);
				end
			end
			default: begin
				if (avg_cnt > AVG_WIN) begin
					r.level = current_level();
					r.calm = (r.level < calm_thresh);
					focus_expected.insert(focus_expected.size(), r);
				end
			end
		endcase
	endtask

	task automatic send_item(input req_type_t req, input logic [23:0] raw);
		int gap;
		gap = $urandom_range(0, src_max_gap);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= raw;
		do @(posedge clk); while (!s_tready);
		advance_calm_state(req, raw);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (focus_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [CFG_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		calm_thresh = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// early ticks, first sample, packet start keeping the last sample, full-scale swings
	task automatic test_directed();
		send_item(REQ_FOCUS_TICK, 24'hFFFFFF);
		send_item(REQ_AVG_TICK, 24'hFFFFFF);
		send_item(REQ_SAMPLE, 24'h7FFFFF);
		send_item(REQ_SAMPLE, 24'h800000);
		send_item(REQ_PACKET, 24'h7FFFFF);
		send_item(REQ_SAMPLE, 24'h800000);
		for (int i = 0; i < 16; i++)
			send_item(REQ_SAMPLE, (i % 2) ? 24'h800000 : 24'h7FFFFF);
		send_item(REQ_AVG_TICK, 24'h000000);
		send_item(REQ_SAMPLE, 24'h000000);
		for (int i = 0; i < 4; i++) begin
			send_item(REQ_AVG_TICK, 24'(i * 24'h555555));
			send_item(REQ_FOCUS_TICK, 24'hAAAAAA);
		end
		send_item(REQ_AVG_TICK, 24'h123456);
		send_item(REQ_FOCUS_TICK, 24'h000000);
	endtask

	task automatic test_threshold_edges();
		logic [LEVEL_W-1:0] lvl;
		set_threshold('0);
		send_item(REQ_FOCUS_TICK, 24'h0);
		set_threshold(THRESH_MAX);
		send_item(REQ_FOCUS_TICK, 24'h0);
		lvl = current_level();
		set_threshold(lvl);
		send_item(REQ_FOCUS_TICK, 24'h0);
		set_threshold(lvl + 1'b1);
		send_item(REQ_FOCUS_TICK, 24'h0);
	endtask

	task automatic test_random_phase(input int n, input logic [CFG_W-1:0] thresh,
		input int step_max, input int gap_max);
		int r;
		logic [23:0] raw;
		set_threshold(thresh);
		src_max_gap = gap_max;
		snk_max_gap = gap_max;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			raw = 24'($urandom);
			if (r < 8) begin
				send_item(REQ_PACKET, raw);
			end else if (r < 60) begin
				if ($urandom_range(0, 4) != 0)
					raw = 24'(walk_smp + $signed($urandom_range(0, 2 * step_max)) - step_max);
				walk_smp = raw;
				send_item(REQ_SAMPLE, raw);
			end else if (r < 82) begin
				send_item(REQ_AVG_TICK, raw);
			end else begin
				send_item(REQ_FOCUS_TICK, raw);
			end
		end
	endtask

	always @(posedge clk) begin
		focus_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (focus_expected.size() == 0) begin
				$display("%0t: unexpected result, actual calm=%0d level=%0d",
					$time, m_tdata[0], m_tdata[LEVEL_W:1]);
				errors++;
			end else begin
				e = focus_expected.pop_front();
				if (m_tdata[0] !== e.calm) begin
					$display("%0t: is_calm expected %0d actual %0d", $time, e.calm, m_tdata[0]);
					errors++;
				end
				if (m_tdata[LEVEL_W:1] !== e.level) begin
					$display("%0t: focus_level expected %0d actual %0d",
						$time, e.level, m_tdata[LEVEL_W:1]);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, snk_max_gap);
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_PACKET;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		src_max_gap = 8;
		snk_max_gap = 8;
		walk_smp = '0;
		prev_smp = '0;
		have_prev = 1'b0;
		foreach (var_ring[i]) var_ring[i] = '0;
		foreach (avg_ring[i]) avg_ring[i] = '0;
		var_ptr = 0;
		var_cnt = 0;
		var_sum = '0;
		avg_ptr = 0;
		avg_cnt = 0;
		avg_sum = '0;
		calm_thresh = CALM_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_threshold_edges();
		test_random_phase(80, CALM_RESET, 1024, 8);
		test_random_phase(80, CFG_W'($urandom_range(0, 4096)), 2048, 0);
		test_random_phase(80, '0, 4096, 8);
		test_random_phase(80, THRESH_MAX, 1024, 3);
		test_random_phase(80, CFG_W'($urandom), 8192, 8);
		test_random_phase(60, CFG_W'($urandom_range(256, 2048)), 512, 0);
		wait_idle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
